// ===== src/selective_repeat_receiver_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Selective-repeat receiver assertion macros
// Shorthand for the concurrent checks at the end of the receiver top level.
// Each macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_ASSERT_SVH

// Condition that must hold at every edge out of reset
`define SRR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define SRR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// srr_pkg
// Shared constants, command format and state types of the selective-repeat
// receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

  // Sequence space and payload word
  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_BITS     = $clog2(SEQ_SPACE);
  localparam int PAYLOAD_BITS = 32;

  // Receive window
  localparam int MAX_WINDOW = 4;
  localparam int WIN_BITS   = 3;
  localparam int WIN_CAP    = (SEQ_SPACE / 2 < MAX_WINDOW) ? SEQ_SPACE / 2 : MAX_WINDOW;
  localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(4);

  // Held packets released after one direct delivery: 0 .. MAX_WINDOW-1
  localparam int CNT_BITS = $clog2(MAX_WINDOW);

  // Stream beat widths, padded to whole bytes
  localparam int BEAT_BITS  = SEQ_BITS + PAYLOAD_BITS;
  localparam int TDATA_BITS = ((BEAT_BITS + 7) / 8) * 8;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Result kind codes on the master tuser bit
  localparam logic RES_DELIVER = 1'b0;
  localparam logic RES_ACK     = 1'b1;

  typedef enum logic [1:0] {
    CMD_ACK,      // valid packet, nothing stored: acknowledge only
    CMD_HOLD,     // store payload, then acknowledge
    CMD_DELIVER   // deliver, release held run, then acknowledge
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [SEQ_BITS-1:0]        seq;
    logic [PAYLOAD_BITS-1:0]    payload;
    logic [CNT_BITS-1:0]        rel_count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIRECT,
    BK_READ,
    BK_RELEASE,
    BK_ACK
  } back_state_t;

endpackage

// ===== src/srr_front.sv =====
// ----------------------------------------------------------------------------
// srr_front
// Accepts packets, keeps the window state (expected number, held flags) and
// turns every intact packet into one command for the back end.
// ----------------------------------------------------------------------------
module srr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [srr_pkg::WIN_BITS-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           checksum_ok,
  input  logic [srr_pkg::SEQ_BITS-1:0]   seq_num,
  input  logic [srr_pkg::PAYLOAD_BITS-1:0] payload_word,
  input  srr_pkg::q_status_t             q_status,
  output logic                           push,
  output srr_pkg::cmd_t                  cmd
);
  import srr_pkg::*;

  logic [WIN_BITS-1:0]  window_size;
  logic [WIN_BITS-1:0]  w_eff;
  logic [SEQ_BITS-1:0]  expected_seq;
  logic [SEQ_BITS-1:0]  expected_seq_next;
  logic [SEQ_SPACE-1:0] held_flags;
  logic [SEQ_SPACE-1:0] held_flags_next;
  logic [SEQ_BITS-1:0]  seq_gap;
  logic [CNT_BITS-1:0]  rel_count;
  logic                 is_deliver;
  logic                 in_window;

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_RESET;
    end else if (cfg_wen) begin
      window_size <= cfg_wdata;
    end
  end

  // Clamp window to 1 .. WIN_CAP
  always_comb begin
    if (window_size == '0) begin
      w_eff = WIN_BITS'(1);
    end else if (window_size > WIN_BITS'(WIN_CAP)) begin
      w_eff = WIN_BITS'(WIN_CAP);
    end else begin
      w_eff = window_size;
    end
  end

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready && checksum_ok;

  // Classify and work out the held run behind an in-order packet
  always_comb begin
    logic                run;
    logic [SEQ_BITS-1:0] idx;
    run             = 1'b1;
    idx             = '0;
    rel_count       = '0;
    held_flags_next = held_flags;
    is_deliver      = (seq_num == expected_seq);
    seq_gap         = seq_num - expected_seq;
    in_window       = (int'(seq_gap) < int'(w_eff));

    if (is_deliver) begin
      held_flags_next[seq_num] = 1'b0;
      for (int i = 0; i < MAX_WINDOW - 1; i++) begin
        idx = expected_seq + SEQ_BITS'(i + 1);
        if (run && (i + 1 < int'(w_eff)) && held_flags[idx]) begin
          rel_count            = rel_count + CNT_BITS'(1);
          held_flags_next[idx] = 1'b0;
        end else begin
          run = 1'b0;
        end
      end
      expected_seq_next = expected_seq + SEQ_BITS'(1) + SEQ_BITS'(rel_count);
    end else begin
      expected_seq_next = expected_seq;
      if (in_window) begin
        held_flags_next[seq_num] = 1'b1;
      end
    end
  end

  // Command for the back end
  always_comb begin
    cmd.seq       = seq_num;
    cmd.payload   = payload_word;
    cmd.rel_count = rel_count;
    if (is_deliver) begin
      cmd.kind = CMD_DELIVER;
    end else if (in_window) begin
      cmd.kind = CMD_HOLD;
    end else begin
      cmd.kind = CMD_ACK;
    end
  end

  // Window state
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= '0;
      held_flags   <= '0;
    end else if (push) begin
      expected_seq <= expected_seq_next;
      held_flags   <= held_flags_next;
    end
  end

endmodule

// ===== src/srr_queue.sv =====
// ----------------------------------------------------------------------------
// srr_queue
// Short command FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module srr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  srr_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output srr_pkg::cmd_t      head,
  output srr_pkg::q_status_t status
);
  import srr_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

  cmd_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_W-1:0]    count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/srr_back.sv =====
// ----------------------------------------------------------------------------
// srr_back
// Carries out commands: owns the held-payload store, emits deliveries,
// releases held packets one by one and closes each packet with its ACK.
// ----------------------------------------------------------------------------
module srr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  srr_pkg::q_status_t               q_status,
  input  srr_pkg::cmd_t                    head,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_kind,
  output logic [srr_pkg::SEQ_BITS-1:0]     out_number,
  output logic [srr_pkg::PAYLOAD_BITS-1:0] out_data_word,
  output logic                             out_last
);
  import srr_pkg::*;

  back_state_t             state;
  back_state_t             state_next;
  cmd_t                    cur;
  logic [SEQ_BITS-1:0]     rel_ptr;
  logic [CNT_BITS-1:0]     rel_left;
  logic [PAYLOAD_BITS-1:0] rd_data;
  logic [PAYLOAD_BITS-1:0] mem [SEQ_SPACE];
  logic                    out_free;
  logic                    load_out;
  logic                    rel_step;
  logic                    res_kind;
  logic [SEQ_BITS-1:0]     res_number;
  logic [PAYLOAD_BITS-1:0] res_data;
  logic                    res_last;

  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          state_next = (head.kind == CMD_DELIVER) ? BK_DIRECT : BK_ACK;
        end
      end
      BK_DIRECT: begin
        if (out_free) begin
          state_next = (cur.rel_count != '0) ? BK_READ : BK_ACK;
        end
      end
      BK_READ: begin
        state_next = BK_RELEASE;
      end
      BK_RELEASE: begin
        if (out_free) begin
          state_next = (rel_left == CNT_BITS'(1)) ? BK_ACK : BK_READ;
        end
      end
      BK_ACK: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop        = 1'b0;
    load_out   = 1'b0;
    rel_step   = 1'b0;
    res_kind   = RES_DELIVER;
    res_number = cur.seq;
    res_data   = cur.payload;
    res_last   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop = !q_status.empty;
      end
      BK_DIRECT: begin
        load_out = out_free;
      end
      BK_READ: begin
      end
      BK_RELEASE: begin
        load_out   = out_free;
        rel_step   = out_free;
        res_number = rel_ptr;
        res_data   = rd_data;
      end
      BK_ACK: begin
        load_out = out_free;
        res_kind = RES_ACK;
        res_data = '0;
        res_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Current command and release walk
  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= head;
      rel_ptr  <= head.seq + SEQ_BITS'(1);
      rel_left <= head.rel_count;
    end else if (rel_step) begin
      rel_ptr  <= rel_ptr + SEQ_BITS'(1);
      rel_left <= rel_left - CNT_BITS'(1);
    end
  end

  // Held-payload store, registered read
  always_ff @(posedge clk) begin
    if (pop && head.kind == CMD_HOLD) begin
      mem[head.seq] <= head.payload;
    end
    rd_data <= mem[rel_ptr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind      <= res_kind;
      out_number    <= res_number;
      out_data_word <= res_data;
      out_last      <= res_last;
    end
  end

endmodule

// ===== src/selective_repeat_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat ARQ receiver
// Packets in on the slave stream, deliveries and ACKs out on the master stream.
// ----------------------------------------------------------------------------
// A packet is taken whenever the two-entry command queue has room; a corrupt
// packet ends there. For a packet that is held or lies outside the window the
// back end pops the queue and sends the ACK; for an in-order packet that
// releases r held packets it pops, sends the direct delivery, does one store
// read plus one beat per release, then sends the ACK; each beat waits on
// back-pressure. The steps are set by the back end sequencer and the single
// registered read port of the held-payload store. The store needs no clearing
// after reset; a packet is released only while its held flag is set.
`include "selective_repeat_receiver_unit_assert.svh"

module selective_repeat_receiver_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [srr_pkg::WIN_BITS-1:0]     cfg_wdata,      // window_size
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [srr_pkg::TDATA_BITS-1:0]   s_axis_tdata,   // seq_num, payload_word, pad
  input  logic                             s_axis_tuser,   // checksum_ok
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [srr_pkg::TDATA_BITS-1:0]   m_axis_tdata,   // number, data_word, pad
  output logic                             m_axis_tuser,   // kind
  output logic                             m_axis_tlast    // last
);
  import srr_pkg::*;

  cmd_t                    q_push_cmd;
  cmd_t                    q_head;
  q_status_t               q_status;
  logic                    q_push;
  logic                    q_pop;
  logic [SEQ_BITS-1:0]     out_number;
  logic [PAYLOAD_BITS-1:0] out_data_word;

  srr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .checksum_ok  (s_axis_tuser),
    .seq_num      (s_axis_tdata[SEQ_BITS-1:0]),
    .payload_word (s_axis_tdata[BEAT_BITS-1:SEQ_BITS]),
    .q_status     (q_status),
    .push         (q_push),
    .cmd          (q_push_cmd)
  );

  srr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  srr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_kind      (m_axis_tuser),
    .out_number    (out_number),
    .out_data_word (out_data_word),
    .out_last      (m_axis_tlast)
  );

  // Pack master beat
  assign m_axis_tdata = TDATA_BITS'({out_data_word, out_number});

  // Checks
  `SRR_ASSERT_IMPL(a_no_push_when_full, q_status.full, !q_push, "command pushed into full queue")
  `SRR_ASSERT_IMPL(a_pop_needs_entry, q_pop, !q_status.empty, "pop from empty queue")
  `SRR_ASSERT_IMPL(a_ack_closes_packet, m_axis_tvalid, m_axis_tuser == m_axis_tlast, "last beat is not the ACK")
  `SRR_ASSERT_IMPL(a_ack_no_data, m_axis_tvalid && m_axis_tuser, out_data_word == '0, "ACK beat carries data")

endmodule

// ===== bench/selective_repeat_receiver_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat receiver testbench
// Sends packets to the receiver and checks every delivery and ACK beat.
// Stimulus is a short directed run, then random packets under several window
// settings. Most random packets land on or near the next in-order number.
// A scoreboard predicts the beats and checks each output beat in order.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_unit_tb;
  import srr_pkg::*;

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [PAYLOAD_BITS-1:0] word_t;

  typedef struct {
    logic  kind;
    seq_t  number;
    word_t word;
    logic  last;
  } rx_beat_t;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int STALL_LIMIT     = 2000;
  localparam int PHASE_PACKETS   = 54;
  // Window per random phase: covers 0, all ones, and the in-range values
  localparam logic [WIN_BITS-1:0] WIN_PLAN [8] = '{3'd1, 3'd7, 3'd2, 3'd0,
                                                   3'd3, 3'd6, 3'd5, 3'd4};

  // --------------------------------------------------------------------------
  // Scoreboard: receiver state copy plus queue of beats still due
  // --------------------------------------------------------------------------
  class arq_rx_scoreboard;
    logic [WIN_BITS-1:0] window_reg;
    seq_t                next_seq;
    bit                  held [SEQ_SPACE];
    word_t               held_word [SEQ_SPACE];
    rx_beat_t            due_beats [$];
    int                  mismatches;

    function new();
      window_reg = WIN_RESET;
      next_seq   = '0;
      foreach (held[i]) held[i] = 1'b0;
      mismatches = 0;
    endfunction

    // Window in force: 0 acts as 1, anything above the cap acts as the cap
    function int eff_window();
      int w;
      w = int'(window_reg);
      if (w < 1) w = 1;
      if (w > WIN_CAP) w = WIN_CAP;
      return w;
    endfunction

    function void add_due(logic kind, seq_t number, word_t word, logic last);
      rx_beat_t b;
      b.kind   = kind;
      b.number = number;
      b.word   = word;
      b.last   = last;
      due_beats.push_back(b);
    endfunction

    // Accepted packet: update state and queue the beats it causes
    function void note_packet(logic ok, seq_t seq, word_t word);
      int   w;
      int   n;
      seq_t gap;
      if (!ok) return;
      w = eff_window();
      if (seq == next_seq) begin
        add_due(RES_DELIVER, seq, word, 1'b0);
        held[seq] = 1'b0;
        next_seq++;
        // release the held run, at most w-1 packets
        n = 1;
        while (n < w && held[next_seq]) begin
          add_due(RES_DELIVER, next_seq, held_word[next_seq], 1'b0);
          held[next_seq] = 1'b0;
          next_seq++;
          n++;
        end
      end else begin
        gap = seq - next_seq;
        if (int'(gap) < w) begin
          held_word[seq] = word;
          held[seq]      = 1'b1;
        end
      end
      add_due(RES_ACK, seq, '0, 1'b1);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    // Accepted output beat: compare with the oldest due beat
    task check_beat(logic kind, seq_t number, word_t word, logic last);
      rx_beat_t want;
      if (due_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0b number %0d word %h",
                                  kind, number, word));
        return;
      end
      want = due_beats.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind got %b want %b", kind, want.kind));
      if (number !== want.number)
        report_mismatch($sformatf("number got %0d want %0d", number, want.number));
      if (word !== want.word)
        report_mismatch($sformatf("data_word got %h want %h", word, want.word));
      if (last !== want.last)
        report_mismatch($sformatf("last got %b want %b", last, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wen;
  logic [WIN_BITS-1:0]   cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_BITS-1:0] s_axis_tdata;   // seq_num, payload_word, pad
  logic                  s_axis_tuser;   // checksum_ok
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_BITS-1:0] m_axis_tdata;   // number, data_word, pad
  logic                  m_axis_tuser;   // kind
  logic                  m_axis_tlast;   // last

  arq_rx_scoreboard sb = new();
  int               send_idle_pct;
  int               recv_idle_pct;
  bit               hold_off_start;

  selective_repeat_receiver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Packet driver
  // --------------------------------------------------------------------------
  // Offer one packet, with random gaps first; valid stays high into the next
  // call unless that call opens with a gap.
  task automatic send_packet(input logic ok, input seq_t seq, input word_t word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_BITS'({word, seq});
    s_axis_tuser  <= ok;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_packet(ok, seq, word);
  endtask

  // Random packet biased toward the next in-order number and the window
  task automatic send_random_packet(input bit on_time);
    int    w;
    int    roll;
    logic  ok;
    seq_t  seq;
    word_t word;
    w    = sb.eff_window();
    roll = $urandom_range(0, 99);
    ok   = 1'b1;
    if (on_time)
      seq = sb.next_seq;
    else if (roll < 10) begin
      ok  = 1'b0;
      seq = seq_t'($urandom);
    end else if (roll < 42)
      seq = sb.next_seq;
    else if (roll < 80)
      seq = sb.next_seq + seq_t'($urandom_range(0, w - 1));
    else
      seq = seq_t'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 5)
      word = '0;
    else if (roll < 10)
      word = '1;
    else
      word = word_t'($urandom);
    send_packet(ok, seq, word);
  endtask

  // Drop valid, wait for all due beats, then let the back end go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.due_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_BITS-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.window_reg = value;
    cfg_wen   <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: checks beats, drives tready with random stalls
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_beat(m_axis_tuser, m_axis_tdata[SEQ_BITS-1:0],
                      m_axis_tdata[SEQ_BITS +: PAYLOAD_BITS], m_axis_tlast);
      if (hold_off_start) begin
        stall_left     = HOLD_OFF_CYCLES;
        hold_off_start = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run after too many cycles with no beat on either side
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("selective_repeat_receiver_unit regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    int k;
    rst           <= 1'b1;
    cfg_wen       <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    hold_off_start = 1'b0;
    send_idle_pct  = 16;
    recv_idle_pct  = 74;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed run at the reset window of 4, next number 0
    send_packet(1'b0, 3'd0, 32'hFFFF_FFFF);   // corrupt: no beat
    send_packet(1'b1, 3'd0, 32'h0000_0000);   // in order
    send_packet(1'b1, 3'd3, 32'hFFFF_FFFF);   // held
    send_packet(1'b1, 3'd2, 32'hAAAA_AAAA);   // held
    send_packet(1'b1, 3'd4, 32'h1234_5678);   // held at the window edge
    send_packet(1'b1, 3'd5, 32'h0F0F_0F0F);   // just past the window: ACK only
    send_packet(1'b1, 3'd3, 32'h5555_5555);   // overwrites held 3
    send_packet(1'b0, 3'd1, 32'hC3C3_C3C3);   // corrupt with the in-order number
    send_packet(1'b1, 3'd1, 32'h8000_0001);   // delivers 1, releases 2..4
    send_packet(1'b1, 3'd4, 32'h7FFF_FFFE);   // old number: ACK only
    send_packet(1'b1, 3'd7, 32'h0000_0001);   // held
    send_packet(1'b1, 3'd5, 32'hFFFF_0000);   // release stops at missing 6
    send_packet(1'b1, 3'd6, 32'h0000_FFFF);   // delivers 6, 7, wraps to 0
    send_packet(1'b0, 3'd7, 32'h0000_0000);   // corrupt
    send_packet(1'b1, 3'd1, 32'h1111_1111);   // held
    send_packet(1'b1, 3'd2, 32'h2222_2222);   // held
    send_packet(1'b1, 3'd3, 32'h3333_3333);   // held
    // Phase 0 opens at window 1 with the in-order number, so the release
    // limit stops the run while 1..3 are still held.

    // Random phases, one window setting each
    for (ph = 0; ph < 8; ph++) begin
      settle();
      write_window(WIN_PLAN[ph]);
      if (ph < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 74;
      end else if (ph < 6) begin
        send_idle_pct = 74;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver hold-off: the block fills and stalls its input
      if (ph == 1) hold_off_start = 1'b1;
      send_random_packet(1'b1);
      for (k = 1; k < PHASE_PACKETS; k++) send_random_packet(1'b0);
    end

    settle();
    if (sb.mismatches == 0)
      $display("selective_repeat_receiver_unit regression: pass");
    else
      $display("selective_repeat_receiver_unit regression: fail");
    $finish;
  end

endmodule
